### design/sfr_pkg.sv
// Package for the serial frame receiver with reply.
// Word types, operation codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

	localparam logic [1:0] OP_RECEIVE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_SHIFT = 2'd2;

	localparam logic [0:0] REG_REPLY_BYTE = 1'd0;
	localparam logic [0:0] REG_REPLY_DELAY = 1'd1;

	localparam logic [7:0] REPLY_BYTE_RST = 8'd6;
	localparam logic [7:0] REPLY_DELAY_RST = 8'd1;

	localparam logic [3:0] RX_WAIT = 4'd0;
	localparam logic [3:0] RX_LAST_DATA = 4'd8;
	localparam logic [3:0] RX_PARITY = 4'd9;
	localparam logic [3:0] RX_STOP1 = 4'd10;
	localparam logic [3:0] RX_STOP2 = 4'd11;

	localparam logic [3:0] TX_START = 4'd0;
	localparam logic [3:0] TX_LAST_DATA = 4'd8;
	localparam logic [3:0] TX_IDLE = 4'd15;

	typedef struct packed {
		logic [1:0] operation;
		logic       rx_bit;
	} in_t;

	typedef struct packed {
		logic       tx_line;
		logic       tx_begin;
		logic       rx_complete;
		logic [7:0] rx_byte;
		logic       rx_parity;
	} out_t;

	typedef struct packed {
		logic complete;
		logic [7:0] data;
		logic parity;
	} rx_stat_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic shift;
	} tx_ctl_t;

	typedef struct packed {
		logic line;
		logic start;
	} tx_stat_t;

endpackage
`default_nettype wire

### design/sfr_rx.sv
// Receive deframer: start bit, eight data bits, parity, two stop bits.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_rx (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             rx_bit,
	output sfr_pkg::rx_stat_t     stat,
	output logic                  frame_ok
);
	import sfr_pkg::*;

	logic [3:0] pos_q, pos_d;
	logic [7:0] shift_q, shift_d;
	logic       parity_q, parity_d;
	logic       complete_q;

	always_comb begin
		pos_d = pos_q;
		shift_d = shift_q;
		parity_d = parity_q;
		frame_ok = 1'b0;
		if (pos_q == RX_WAIT) begin
			shift_d = 8'd0;
			if (!rx_bit) begin
				pos_d = 4'd1;
			end
		end else if (pos_q <= RX_LAST_DATA) begin
			shift_d = {rx_bit, shift_q[7:1]};
			pos_d = pos_q + 4'd1;
		end else if (pos_q == RX_PARITY) begin
			parity_d = rx_bit;
			pos_d = RX_STOP1;
		end else if (pos_q == RX_STOP1) begin
			pos_d = rx_bit ? RX_STOP2 : RX_WAIT;
		end else if (pos_q == RX_STOP2) begin
			frame_ok = rx_bit;
			pos_d = RX_WAIT;
		end else begin
			pos_d = RX_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= RX_WAIT;
			shift_q <= 8'd0;
			parity_q <= 1'b0;
			complete_q <= 1'b0;
		end else if (en) begin
			pos_q <= pos_d;
			shift_q <= shift_d;
			parity_q <= parity_d;
			complete_q <= frame_ok;
		end
	end

	always_comb begin
		stat.complete = en ? frame_ok : complete_q;
		stat.data = en ? shift_d : shift_q;
		stat.parity = en ? parity_d : parity_q;
	end

endmodule
`default_nettype wire

### design/sfr_tx.sv
// Reply timer and transmit shifter: countdown, start bit, data LSB first.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_tx (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sfr_pkg::tx_ctl_t ctl,
	input  wire logic [7:0]       reply_byte,
	input  wire logic [7:0]       reply_delay,
	output sfr_pkg::tx_stat_t     stat
);
	import sfr_pkg::*;

	logic [3:0] pos_q, pos_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] timer_q, timer_d;
	logic       line_q, line_d;
	logic       start;

	assign start = ctl.tick && (timer_q == 8'd1);

	always_comb begin
		pos_d = pos_q;
		shift_d = shift_q;
		timer_d = timer_q;
		line_d = line_q;
		if (ctl.load) begin
			timer_d = reply_delay;
			shift_d = reply_byte;
		end
		if (ctl.tick && (timer_q != 8'd0)) begin
			timer_d = timer_q - 8'd1;
		end
		if (start) begin
			line_d = 1'b0;
			pos_d = TX_START;
		end
		if (ctl.shift) begin
			if (pos_q == TX_START) begin
				pos_d = 4'd1;
			end else if (pos_q <= TX_LAST_DATA) begin
				line_d = shift_q[0];
				shift_d = {1'b0, shift_q[7:1]};
				pos_d = pos_q + 4'd1;
			end else begin
				line_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= TX_IDLE;
			shift_q <= 8'd0;
			timer_q <= 8'd0;
			line_q <= 1'b1;
		end else begin
			pos_q <= pos_d;
			shift_q <= shift_d;
			timer_q <= timer_d;
			line_q <= line_d;
		end
	end

	assign stat.line = line_d;
	assign stat.start = start;

endmodule
`default_nettype wire

### design/serial_frame_rx_with_auto_reply.sv
// Top level of the serial frame receiver with automatic reply.
// Input register, receive and transmit units, result register. Uses sfr_pkg.
//
//   channel   direction   handshake           payload
//   in        input       in_valid/in_stall   in_word (operation, rx_bit)
//   out       output      out_valid/out_stall out_word (tx_line .. rx_parity)
//   cfg       input       cfg_we              cfg_index, cfg_data
//
// Each accepted word is held in the input register, then passes through the
// state update into the result register. One word per cycle is sustained
// while out_stall stays low. Reset clears all but the word registers;
// reply_byte resets to 6, reply_delay to 1.
// A stalled result holds; the input register fills and then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_rx_with_auto_reply (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire sfr_pkg::in_t  in_word,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sfr_pkg::out_t      out_word,
	input  wire logic          cfg_we,
	input  wire logic [0:0]    cfg_index,
	input  wire logic [7:0]    cfg_data
);
	import sfr_pkg::*;

	logic [7:0] reply_byte_q;
	logic [7:0] reply_delay_q;
	logic       valid_s1;
	in_t        word_s1;
	logic       advance;
	logic       rx_en;
	logic       frame_ok;
	rx_stat_t   rx_stat;
	tx_ctl_t    tx_ctl;
	tx_stat_t   tx_stat;
	logic       out_valid_q;
	out_t       out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_byte_q <= REPLY_BYTE_RST;
			reply_delay_q <= REPLY_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPLY_BYTE: reply_byte_q <= cfg_data;
				REG_REPLY_DELAY: reply_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	assign rx_en = advance && (word_s1.operation == OP_RECEIVE);

	sfr_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rx_en),
		.rx_bit   (word_s1.rx_bit),
		.stat     (rx_stat),
		.frame_ok (frame_ok)
	);

	always_comb begin
		tx_ctl.load = rx_en && frame_ok;
		tx_ctl.tick = advance && (word_s1.operation == OP_TICK);
		tx_ctl.shift = advance && (word_s1.operation == OP_SHIFT);
	end

	sfr_tx u_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (tx_ctl),
		.reply_byte  (reply_byte_q),
		.reply_delay (reply_delay_q),
		.stat        (tx_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.tx_line <= tx_stat.line;
			out_word_q.tx_begin <= tx_stat.start;
			out_word_q.rx_complete <= rx_stat.complete;
			out_word_q.rx_byte <= rx_stat.data;
			out_word_q.rx_parity <= rx_stat.parity;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

`ifndef ASSERT_OFF
	a_begin_drives_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.tx_begin |-> !out_word.tx_line)
		else $error("reply start without low line");

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result word changed");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed word did not reach the result register");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for serial_frame_rx_with_auto_reply: serial frames, timer ticks and reply shifts.
// A scoreboard class predicts every result word, and plain tasks drive the ports.
// Depends on sfr_pkg and the serial_frame_rx_with_auto_reply top level.
`timescale 1ns / 1ps
module tb_top;
	import sfr_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT = 5000;

	class frame_scoreboard;
		logic [7:0] reply_byte;
		logic [7:0] reply_delay;
		logic [3:0] rx_pos;
		logic [7:0] rx_shift;
		logic       parity;
		logic       complete;
		logic [3:0] tx_pos;
		logic [7:0] tx_shift;
		logic [7:0] timer;
		logic       line;
		out_t       expected_q[$];
		int         errors;
		int         checked;
		int         starts_seen;
		int         frames_good;

		function new();
			reply_byte = REPLY_BYTE_RST;
			reply_delay = REPLY_DELAY_RST;
			rx_pos = RX_WAIT;
			rx_shift = '0;
			parity = 1'b0;
			complete = 1'b0;
			tx_pos = TX_IDLE;
			tx_shift = '0;
			timer = '0;
			line = 1'b1;
			errors = 0;
			checked = 0;
			starts_seen = 0;
			frames_good = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [7:0] data);
			if (idx == REG_REPLY_BYTE)
				reply_byte = data;
			else
				reply_delay = data;
		endfunction

		function void note_word(in_t w);
			logic started;
			out_t res;
			started = 1'b0;
			case (w.operation)
				OP_RECEIVE: begin
					complete = 1'b0;
					if (rx_pos == RX_WAIT) begin
						rx_shift = '0;
						if (!w.rx_bit)
							rx_pos = RX_WAIT + 4'd1;
					end else if (rx_pos <= RX_LAST_DATA) begin
						rx_shift = {w.rx_bit, rx_shift[7:1]};
						rx_pos = rx_pos + 4'd1;
					end else if (rx_pos == RX_PARITY) begin
						parity = w.rx_bit;
						rx_pos = RX_STOP1;
					end else if (rx_pos == RX_STOP1) begin
						rx_pos = w.rx_bit ? RX_STOP2 : RX_WAIT;
					end else if (rx_pos == RX_STOP2) begin
						if (w.rx_bit) begin
							complete = 1'b1;
							timer = reply_delay;
							tx_shift = reply_byte;
							frames_good++;
						end
						rx_pos = RX_WAIT;
					end else begin
						rx_pos = RX_WAIT;
					end
				end
				OP_TICK: begin
					if (timer != 8'd0) begin
						timer = timer - 8'd1;
						if (timer == 8'd0) begin
							line = 1'b0;
							tx_pos = TX_START;
							started = 1'b1;
						end
					end
				end
				OP_SHIFT: begin
					if (tx_pos == TX_START) begin
						tx_pos = TX_START + 4'd1;
					end else if (tx_pos <= TX_LAST_DATA) begin
						line = tx_shift[0];
						tx_shift = tx_shift >> 1;
						tx_pos = tx_pos + 4'd1;
					end else begin
						line = 1'b1;
					end
				end
				default: ;
			endcase
			res.tx_line = line;
			res.tx_begin = started;
			res.rx_complete = complete;
			res.rx_byte = rx_shift;
			res.rx_parity = parity;
			expected_q.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at result %0d: %s", checked, msg);
		endtask

		task check_result(out_t got);
			out_t exp;
			if (expected_q.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			exp = expected_q.pop_front();
			if (got.tx_line !== exp.tx_line)
				report($sformatf("tx_line %b, expected %b", got.tx_line, exp.tx_line));
			if (got.tx_begin !== exp.tx_begin)
				report($sformatf("tx_begin %b, expected %b", got.tx_begin, exp.tx_begin));
			if (got.rx_complete !== exp.rx_complete)
				report($sformatf("rx_complete %b, expected %b",
					got.rx_complete, exp.rx_complete));
			if (got.rx_byte !== exp.rx_byte)
				report($sformatf("rx_byte %h, expected %h", got.rx_byte, exp.rx_byte));
			if (got.rx_parity !== exp.rx_parity)
				report($sformatf("rx_parity %b, expected %b", got.rx_parity, exp.rx_parity));
			if (exp.tx_begin)
				starts_seen++;
			checked++;
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_t        in_word = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_word;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_REPLY_BYTE;
	logic [7:0] cfg_data = '0;

	frame_scoreboard sb;
	int send_idle_pct = 7;
	int recv_stall_pct = 78;
	int words_sent = 0;

	serial_frame_rx_with_auto_reply dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_word(in_word);
			if (out_valid && !out_stall)
				sb.check_result(out_word);
		end
	end

	function automatic in_t mk_word(logic [1:0] op, logic b);
		in_t w;
		w.operation = op;
		w.rx_bit = b;
		return w;
	endfunction

	task automatic send_word(in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
	endtask

	task automatic send_run(logic [1:0] op, int n);
		repeat (n)
			send_word(mk_word(op, 1'($urandom_range(1))));
	endtask

	// start bit, data LSB first, parity, two stop bits; optional ticks and shifts between bits
	task automatic send_frame(logic [7:0] data, logic par, logic s1, logic s2, int noise_pct);
		logic [11:0] bits;
		bits = {s2, s1, par, data, 1'b0};
		for (int i = 0; i < 12; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_word(mk_word($urandom_range(1) ? OP_TICK : OP_SHIFT,
					1'($urandom_range(1))));
			send_word(mk_word(OP_RECEIVE, bits[i]));
		end
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.expected_q.size() != 0) begin
			sb.report($sformatf("%0d result words never arrived", sb.expected_q.size()));
			sb.expected_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 60) begin
			send_frame(8'($urandom), 1'($urandom_range(1)), $urandom_range(99) >= 10,
				$urandom_range(99) >= 10, 15);
		end else if (pick < 82) begin
			if (sb.reply_delay > 8'd16 && $urandom_range(3) == 0)
				n = sb.reply_delay + $urandom_range(4);
			else
				n = $urandom_range(1, 6);
			send_run(OP_TICK, n);
		end else if (pick < 94) begin
			send_run(OP_SHIFT, $urandom_range(1, 11));
		end else begin
			repeat ($urandom_range(1, 4))
				send_word(mk_word(2'($urandom_range(3)), 1'($urandom_range(1))));
		end
	endtask

	task automatic run_phase(logic [7:0] rbyte, logic [7:0] rdelay, int n,
		int send_pct, int recv_pct);
		int target;
		drain();
		write_reg(REG_REPLY_BYTE, rbyte);
		write_reg(REG_REPLY_DELAY, rdelay);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		target = words_sent + n;
		while (words_sent < target)
			random_sequence();
		drain();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: reply byte 6 after one tick
		send_word(mk_word(OP_RECEIVE, 1'b1));
		send_word(mk_word(OP_UNUSED, 1'b1));
		send_frame(8'hFF, 1'b1, 1'b1, 1'b1, 0);
		send_word(mk_word(OP_SHIFT, 1'b0));
		send_word(mk_word(OP_TICK, 1'b0));
		send_word(mk_word(OP_TICK, 1'b1));
		send_run(OP_SHIFT, 2);
		send_frame(8'h00, 1'b0, 1'b1, 1'b0, 0);

		run_phase(8'h00, 8'd1, 300, 7, 78);
		run_phase(8'hFF, 8'd255, 600, 7, 78);
		run_phase(8'($urandom), 8'd0, 150, 78, 7);
		run_phase(8'($urandom), 8'($urandom_range(2, 9)), 300, 78, 7);
		run_phase(8'hA5, 8'd2, 200, 0, 0);
		run_phase(8'($urandom), 8'($urandom_range(1, 12)), 200, 0, 0);

		$display("Sent %0d words, checked %0d results, %0d good frames, %0d reply starts",
			words_sent, sb.checked, sb.frames_good, sb.starts_seen);
		$display("Reply bytes 00, FF, A5 and random; delays 0, 1, 2, 255 and small random");
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end
endmodule
